FILE: hdl/opponent_tracking_drive_macros.svh
// Assertion macros shared by the opponent tracking drive modules.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef OPPONENT_TRACKING_DRIVE_MACROS_SVH
`define OPPONENT_TRACKING_DRIVE_MACROS_SVH

// Same-cycle implication, disabled during reset
`define OTD_ASSERT_IMPL(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define OTD_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

FILE: hdl/otd_pkg.sv
// Package for the opponent tracking drive: payload, configuration and command types,
// fixed widths, mode codes and the sensor-pattern error table. No dependencies.
package otd_pkg;

    localparam int ADC_BITS  = 12;
    localparam int DRIVE_W   = 8;
    localparam int ERR_W     = 12;
    localparam int TICK_W    = 16;
    localparam int PWR_W     = 15;      // power in hundredths, -10000..10000
    localparam int NUM_W     = 22;      // drive numerator before the constant divide
    localparam int QUOT_W    = 8;       // drive byte produced by the divider

    localparam int POWER_MAX = 10000;   // 100.00 in hundredths
    localparam int LEFT_DIV  = 10000;   // left byte = floor(num / 10000)
    localparam int RIGHT_DIV = 12500;   // right byte after the 0.8 scale

    localparam logic [1:0] MODE_TRACK   = 2'd0;
    localparam logic [1:0] MODE_REVERSE = 2'd1;
    localparam logic [1:0] MODE_SPIN    = 2'd2;

    // Configuration register indexes
    localparam logic [2:0] REG_STOP_LEFT      = 3'd0;
    localparam logic [2:0] REG_STOP_RIGHT     = 3'd1;
    localparam logic [2:0] REG_EDGE_THRESHOLD = 3'd2;
    localparam logic [2:0] REG_SPEED_SLOW     = 3'd3;
    localparam logic [2:0] REG_SPEED_FAST     = 3'd4;
    localparam logic [2:0] REG_CENTER_BAND    = 3'd5;
    localparam logic [2:0] REG_REVERSE_TICKS  = 3'd6;
    localparam logic [2:0] REG_SPIN_TICKS     = 3'd7;

    typedef struct packed {
        logic                opp_pos1;
        logic                opp_pos2;
        logic                opp_pos3;
        logic                opp_pos4;
        logic                opp_pos5;
        logic [ADC_BITS-1:0] edge_front;
        logic [ADC_BITS-1:0] edge_rear;
    } in_item_t;

    typedef struct packed {
        logic [DRIVE_W-1:0]      left_drive;
        logic [DRIVE_W-1:0]      right_drive;
        logic signed [ERR_W-1:0] steer_error;
        logic [1:0]              mode;
    } out_item_t;

    typedef struct packed {
        logic [7:0]          stop_left;
        logic [7:0]          stop_right;
        logic [ADC_BITS-1:0] edge_threshold;
        logic [6:0]          speed_slow;
        logic [6:0]          speed_fast;
        logic [10:0]         center_band;
        logic [TICK_W-1:0]   reverse_ticks;
        logic [TICK_W-1:0]   spin_ticks;
    } cfg_t;

    typedef struct packed {
        logic load;        // request accepted: update error and escape state
        logic power;       // register clamped left/right powers
        logic div_start;   // form numerators and load the dividers
        logic div_step;    // two quotient bits per divider
        logic out_load;    // move the finished result into the output register
    } dp_cmd_t;

    // Centroid of the lit sensors minus the centre position (weights 1000..5000).
    // Bit 0 is sensor 1. The all-dark pattern is never used.
    function automatic logic signed [ERR_W-1:0] err_of_pattern(input logic [4:0] lit);
        logic signed [ERR_W-1:0] e;
        case (lit)
            5'd1:    e = -12'sd2000;
            5'd2:    e = -12'sd1000;
            5'd3:    e = -12'sd1500;
            5'd4:    e =  12'sd0;
            5'd5:    e = -12'sd1000;
            5'd6:    e = -12'sd500;
            5'd7:    e = -12'sd1000;
            5'd8:    e =  12'sd1000;
            5'd9:    e = -12'sd500;
            5'd10:   e =  12'sd0;
            5'd11:   e = -12'sd667;
            5'd12:   e =  12'sd500;
            5'd13:   e = -12'sd334;
            5'd14:   e =  12'sd0;
            5'd15:   e = -12'sd500;
            5'd16:   e =  12'sd2000;
            5'd17:   e =  12'sd0;
            5'd18:   e =  12'sd500;
            5'd19:   e = -12'sd334;
            5'd20:   e =  12'sd1000;
            5'd21:   e =  12'sd0;
            5'd22:   e =  12'sd333;
            5'd23:   e = -12'sd250;
            5'd24:   e =  12'sd1500;
            5'd25:   e =  12'sd333;
            5'd26:   e =  12'sd666;
            5'd27:   e =  12'sd0;
            5'd28:   e =  12'sd1000;
            5'd29:   e =  12'sd250;
            5'd30:   e =  12'sd500;
            5'd31:   e =  12'sd0;
            default: e =  12'sd0;
        endcase
        return e;
    endfunction

endpackage

FILE: hdl/opponent_tracking_drive.sv
// Opponent tracking drive: one request per control tick, one result per request.
// A new request is accepted only after the previous result has entered the output register.
// The result is formed by the power stage, the product stage and four two-bit steps
// of the constant dividers that form the drive bytes.
// Reset (rst_n low, asynchronous): registers to their defaults, error zero, tracking mode.
// Uses otd_pkg, otd_ctrl, otd_dp.
module opponent_tracking_drive
    import otd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  in_item_t   in_data,
    output logic       out_valid,
    input  logic       out_stall,
    output out_item_t  out_data,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [2:0] cfg_index,
    input  logic [15:0] cfg_data
);

    localparam cfg_t CFG_RESET = '{
        stop_left:      8'd140,
        stop_right:     8'd140,
        edge_threshold: 12'd300,
        speed_slow:     7'd70,
        speed_fast:     7'd90,
        center_band:    11'd100,
        reverse_ticks:  16'd150,
        spin_ticks:     16'd200
    };

    cfg_t    cfg_reg;
    dp_cmd_t cmd;

    assign cfg_ready = 1'b1;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_STOP_LEFT:      cfg_reg.stop_left      <= cfg_data[7:0];
                REG_STOP_RIGHT:     cfg_reg.stop_right     <= cfg_data[7:0];
                REG_EDGE_THRESHOLD: cfg_reg.edge_threshold <= cfg_data[ADC_BITS-1:0];
                REG_SPEED_SLOW:     cfg_reg.speed_slow     <= cfg_data[6:0];
                REG_SPEED_FAST:     cfg_reg.speed_fast     <= cfg_data[6:0];
                REG_CENTER_BAND:    cfg_reg.center_band    <= cfg_data[10:0];
                REG_REVERSE_TICKS:  cfg_reg.reverse_ticks  <= cfg_data[TICK_W-1:0];
                REG_SPIN_TICKS:     cfg_reg.spin_ticks     <= cfg_data[TICK_W-1:0];
                default:            cfg_reg                <= cfg_reg;
            endcase
        end
    end

    otd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    otd_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .cfg      (cfg_reg),
        .in_data  (in_data),
        .out_data (out_data)
    );

endmodule

FILE: hdl/otd_cdiv.sv
// Divider by a fixed constant: restoring, two quotient bits per step.
// Depends on otd_pkg for the numerator and quotient widths.
`include "opponent_tracking_drive_macros.svh"

module otd_cdiv
    import otd_pkg::*;
#(
    parameter int DIVISOR = 10000
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              step,
    input  logic [NUM_W-1:0]  num,
    output logic [QUOT_W-1:0] quot
);

    localparam logic [NUM_W-1:0] DIV_TOP   = NUM_W'(DIVISOR) << (QUOT_W - 1);
    localparam logic [NUM_W-1:0] DIV_LIMIT = NUM_W'(DIVISOR) << QUOT_W;

    logic [NUM_W-1:0]  rem_reg;
    logic [NUM_W-1:0]  dsr_reg;
    logic [QUOT_W-1:0] quot_reg;

    logic [NUM_W-1:0] dsr_half;
    logic [NUM_W-1:0] rem_mid;
    logic [NUM_W-1:0] rem_next;
    logic             bit_hi;
    logic             bit_lo;

    // Two restoring compare/subtract steps
    always_comb
    begin
        dsr_half = dsr_reg >> 1;
        bit_hi   = (rem_reg >= dsr_reg);
        rem_mid  = bit_hi ? (rem_reg - dsr_reg) : rem_reg;
        bit_lo   = (rem_mid >= dsr_half);
        rem_next = bit_lo ? (rem_mid - dsr_half) : rem_mid;
    end

    // Load the numerator, then shift in quotient bits
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= num;
            dsr_reg  <= DIV_TOP;
            quot_reg <= '0;
        end
        else if (step)
        begin
            rem_reg  <= rem_next;
            dsr_reg  <= dsr_reg >> 2;
            quot_reg <= {quot_reg[QUOT_W-3:0], bit_hi, bit_lo};
        end
    end

    assign quot = quot_reg;

    // The quotient must fit the drive byte
    `OTD_ASSERT_NEXT(a_num_in_range, start, rem_reg < DIV_LIMIT, "divider numerator too large")

endmodule

FILE: hdl/otd_dp.sv
// Datapath of the opponent tracking drive: steering error, escape timing, powers,
// drive numerators, two constant dividers and the output register. Uses otd_pkg, otd_cdiv.
module otd_dp
    import otd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  dp_cmd_t   cmd,
    input  cfg_t      cfg,
    input  in_item_t  in_data,
    output out_item_t out_data
);

    typedef struct packed {
        logic [1:0]        phase;
        logic [TICK_W-1:0] left;
    } esc_t;

    // Leave finished escape phases; a zero-length phase is skipped at once
    function automatic esc_t settle(input esc_t s, input logic [TICK_W-1:0] spin);
        esc_t r;
        r = s;
        if (r.phase == MODE_REVERSE && r.left == '0)
        begin
            r.phase = MODE_SPIN;
            r.left  = spin;
        end
        if (r.phase == MODE_SPIN && r.left == '0)
        begin
            r.phase = MODE_TRACK;
        end
        if (r.phase != MODE_TRACK && r.phase != MODE_REVERSE && r.phase != MODE_SPIN)
        begin
            r.phase = MODE_TRACK;
        end
        return r;
    endfunction

    function automatic logic signed [PWR_W-1:0] clamp_power(input logic signed [16:0] v);
        logic signed [PWR_W-1:0] r;
        if (v > 17'sd10000)
        begin
            r = PWR_W'(POWER_MAX);
        end
        else if (v < -17'sd10000)
        begin
            r = -PWR_W'(POWER_MAX);
        end
        else
        begin
            r = v[PWR_W-1:0];
        end
        return r;
    endfunction

    logic signed [ERR_W-1:0] err_reg;
    logic [1:0]              phase_reg;
    logic [TICK_W-1:0]       left_reg;
    logic signed [PWR_W-1:0] pl_reg;
    logic signed [PWR_W-1:0] pr_reg;
    out_item_t               out_reg;

    // ---- tick update: error and escape sequencing ----
    logic [4:0]              lit;
    logic                    edge_low;
    esc_t                    esc_a;
    esc_t                    esc_b;
    esc_t                    esc_c;
    logic [TICK_W-1:0]       left_next;

    always_comb
    begin
        lit = {in_data.opp_pos5, in_data.opp_pos4, in_data.opp_pos3,
               in_data.opp_pos2, in_data.opp_pos1};
        edge_low = (in_data.edge_front < cfg.edge_threshold) ||
                   (in_data.edge_rear  < cfg.edge_threshold);
        esc_a = settle('{phase: phase_reg, left: left_reg}, cfg.spin_ticks);
        esc_b = settle('{phase: MODE_REVERSE, left: cfg.reverse_ticks}, cfg.spin_ticks);
        esc_c = (esc_a.phase == MODE_TRACK && edge_low) ? esc_b : esc_a;
        left_next = (esc_c.phase != MODE_TRACK) ? (esc_c.left - 1'b1) : esc_c.left;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            err_reg   <= '0;
            phase_reg <= MODE_TRACK;
            left_reg  <= '0;
        end
        else if (cmd.load)
        begin
            if (lit != 5'd0)
            begin
                err_reg <= err_of_pattern(lit);
            end
            phase_reg <= esc_c.phase;
            left_reg  <= left_next;
        end
    end

    // ---- power stage: base speed plus or minus error*10, clamped; full power while escaping ----
    logic [ERR_W-1:0]        err_mag;
    logic [6:0]              speed;
    logic [13:0]             base;
    logic signed [15:0]      err10;
    logic signed [16:0]      sum_l;
    logic signed [16:0]      sum_r;

    always_comb
    begin
        err_mag = err_reg[ERR_W-1] ? ERR_W'(-err_reg) : ERR_W'(err_reg);
        speed   = (err_mag < {1'b0, cfg.center_band}) ? cfg.speed_fast : cfg.speed_slow;
        base    = 14'(speed) * 14'd100;
        err10   = 16'(err_reg) * 16'sd10;
        sum_l   = $signed({3'b000, base}) + 17'(err10);
        sum_r   = $signed({3'b000, base}) - 17'(err10);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.power)
        begin
            case (phase_reg)
                MODE_REVERSE:
                begin
                    pl_reg <= -PWR_W'(POWER_MAX);
                    pr_reg <= -PWR_W'(POWER_MAX);
                end
                MODE_SPIN:
                begin
                    pl_reg <= -PWR_W'(POWER_MAX);
                    pr_reg <= PWR_W'(POWER_MAX);
                end
                default:
                begin
                    pl_reg <= clamp_power(sum_l);
                    pr_reg <= clamp_power(sum_r);
                end
            endcase
        end
    end

    // ---- product stage: stop byte plus rate times power ----
    // Right side is negated and scaled by 0.8, folded into its divisor of 12500.
    logic [7:0]              rate_l;
    logic [7:0]              rate_r;
    logic signed [23:0]      prod_l;
    logic signed [23:0]      prod_r;
    logic signed [23:0]      full_l;
    logic signed [23:0]      full_r;
    logic [NUM_W-1:0]        num_l;
    logic [NUM_W-1:0]        num_r;

    always_comb
    begin
        rate_l = pl_reg[PWR_W-1] ? cfg.stop_left : (8'd255 - cfg.stop_left);
        rate_r = (pr_reg > 0) ? cfg.stop_right : (8'd255 - cfg.stop_right);
        prod_l = $signed({1'b0, rate_l}) * pl_reg;
        prod_r = $signed({1'b0, rate_r}) * pr_reg;
        full_l = $signed(24'(cfg.stop_left) * 24'(LEFT_DIV)) + prod_l;
        full_r = $signed(24'(cfg.stop_right) * 24'(RIGHT_DIV)) - prod_r;
        num_l  = full_l[NUM_W-1:0];
        num_r  = full_r[NUM_W-1:0];
    end

    logic [QUOT_W-1:0] quot_l;
    logic [QUOT_W-1:0] quot_r;

    otd_cdiv #(.DIVISOR(LEFT_DIV)) u_div_left (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .step  (cmd.div_step),
        .num   (num_l),
        .quot  (quot_l)
    );

    otd_cdiv #(.DIVISOR(RIGHT_DIV)) u_div_right (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .step  (cmd.div_step),
        .num   (num_r),
        .quot  (quot_r)
    );

    // Hold the result for the output side
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_reg.left_drive  <= quot_l;
            out_reg.right_drive <= quot_r;
            out_reg.steer_error <= err_reg;
            out_reg.mode        <= phase_reg;
        end
    end

    assign out_data = out_reg;

endmodule

FILE: hdl/otd_ctrl.sv
// Controller of the opponent tracking drive: sequences one request through the
// datapath and owns the output valid flag. Uses otd_pkg.
`include "opponent_tracking_drive_macros.svh"

module otd_ctrl
    import otd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_stall,
    output logic    out_valid,
    input  logic    out_stall,
    output dp_cmd_t cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_POWER,
        ST_MUL,
        ST_DIV,
        ST_DONE
    } state_t;

    state_t     state_reg;
    logic [1:0] step_cnt_reg;
    logic       out_valid_reg;

    // Decode commands from the current state
    always_comb
    begin
        cmd.load      = (state_reg == ST_IDLE) && in_valid;
        cmd.power     = (state_reg == ST_POWER);
        cmd.div_start = (state_reg == ST_MUL);
        cmd.div_step  = (state_reg == ST_DIV);
        cmd.out_load  = (state_reg == ST_DONE) && (!out_valid_reg || !out_stall);
    end

    // Advance the sequence and track the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg <= ST_POWER;
                    end
                end
                ST_POWER:
                begin
                    state_reg <= ST_MUL;
                end
                ST_MUL:
                begin
                    step_cnt_reg <= '0;
                    state_reg    <= ST_DIV;
                end
                ST_DIV:
                begin
                    step_cnt_reg <= step_cnt_reg + 1'b1;
                    if (step_cnt_reg == 2'd3)
                    begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase

            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

    `OTD_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "accepted request did not block the input")
    `OTD_ASSERT_IMPL(a_free_after_result, $fell(in_stall), $past(cmd.out_load), "input freed without a result")
    `OTD_ASSERT_NEXT(a_div_full_length, cmd.div_start, cmd.div_step && step_cnt_reg == 2'd0, "divide sequence did not start at step zero")

endmodule

FILE: verif/tb_opponent_tracking_drive.sv
`timescale 1ns / 1ps
// Self-checking testbench for opponent_tracking_drive: directed rows, then random phases.
// Depends on otd_pkg and the block's RTL. Results are predicted in-bench, tick by tick.
module tb_opponent_tracking_drive;
    import otd_pkg::*;

    localparam int NUM_REGS        = 8;
    localparam int SETTLE_CYCLES   = 12;
    localparam int DRAIN_GUARD     = 5000;
    localparam int NUM_PHASES      = 11;
    localparam int ITEMS_PER_PHASE = 50;
    localparam int PRINT_LIMIT     = 40;

    typedef struct {
        bit          is_write;
        logic [2:0]  reg_index;
        logic [15:0] reg_value;
        in_item_t    item;
        bit          typed;
        out_item_t   typed_res;
    } step_row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    in_item_t    in_data;
    logic        out_valid;
    logic        out_stall;
    out_item_t   out_data;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;

    // Predictor copy of the block's registers and state
    cfg_t        cfg_now;
    int          err_hold;
    logic [1:0]  esc_phase;
    logic [15:0] esc_remaining;

    out_item_t   pending_drive_q[$];
    step_row_t   directed_rows[$];
    out_item_t   want_res;
    int          mismatch_count;
    bit          sender_no_gaps;

    opponent_tracking_drive dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Hard stop in case the block hangs
    initial
    begin
        #10_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
            $display("[%0t] drive result %s: got %0d, want %0d", $time, what, got, want);
    endtask

    function automatic int clamp_span(input int v, input int lo, input int hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // Drive byte from a power in thousandths: floor(stop + rate * power / 100000)
    function automatic logic [7:0] drive_byte_of(input int stop, input int p1000,
                                                 input bit zero_rises);
        longint rate;
        longint num;
        rate = (p1000 > 0 || (p1000 == 0 && zero_rises)) ? 255 - stop : stop;
        num = longint'(stop) * 100000 + rate * p1000;
        if (num < 0)
            num = 0;
        return 8'(num / 100000);
    endfunction

    // Advance the escape sequence past any phase that has run out
    function automatic void settle_escape();
        if (esc_phase == MODE_REVERSE && esc_remaining == 16'd0)
        begin
            esc_phase = MODE_SPIN;
            esc_remaining = cfg_now.spin_ticks;
        end
        if (esc_phase == MODE_SPIN && esc_remaining == 16'd0)
            esc_phase = MODE_TRACK;
    endfunction

    // Work out one tick's drive result and advance the predicted state
    function automatic out_item_t predict_drive(input in_item_t it);
        out_item_t  res;
        logic [4:0] lit;
        int         lit_count;
        int         weight_sum;
        int         mag;
        int         speed;
        int         pl;
        int         pr;
        int         l1000;
        int         r1000;
        bit         edge_low;
        lit = {it.opp_pos5, it.opp_pos4, it.opp_pos3, it.opp_pos2, it.opp_pos1};
        lit_count = 0;
        weight_sum = 0;
        for (int k = 0; k < 5; k++)
        begin
            if (lit[k])
            begin
                lit_count++;
                weight_sum += 1000 * (k + 1);
            end
        end
        if (lit_count != 0)
            err_hold = weight_sum / lit_count - 3000;

        edge_low = (it.edge_front < cfg_now.edge_threshold) ||
                   (it.edge_rear < cfg_now.edge_threshold);
        settle_escape();
        if (esc_phase == MODE_TRACK && edge_low)
        begin
            esc_phase = MODE_REVERSE;
            esc_remaining = cfg_now.reverse_ticks;
            settle_escape();
        end

        if (esc_phase == MODE_REVERSE)
        begin
            l1000 = -100000;
            r1000 = 80000;
        end
        else if (esc_phase == MODE_SPIN)
        begin
            l1000 = -100000;
            r1000 = -80000;
        end
        else
        begin
            mag = (err_hold < 0) ? -err_hold : err_hold;
            speed = (mag < int'(cfg_now.center_band)) ? int'(cfg_now.speed_fast)
                                                      : int'(cfg_now.speed_slow);
            pl = clamp_span(speed * 100 + err_hold * 10, -10000, 10000);
            pr = clamp_span(speed * 100 - err_hold * 10, -10000, 10000);
            l1000 = pl * 10;
            r1000 = clamp_span(-pr * 8, -100000, 100000);
        end
        res.mode = esc_phase;
        if (esc_phase != MODE_TRACK)
            esc_remaining = esc_remaining - 16'd1;

        res.left_drive  = drive_byte_of(int'(cfg_now.stop_left), l1000, 1'b1);
        res.right_drive = drive_byte_of(int'(cfg_now.stop_right), r1000, 1'b0);
        res.steer_error = 12'(err_hold);
        return res;
    endfunction

    function automatic in_item_t make_item(input logic [4:0] lit, input logic [11:0] front,
                                           input logic [11:0] rear);
        in_item_t it;
        it.opp_pos1   = lit[0];
        it.opp_pos2   = lit[1];
        it.opp_pos3   = lit[2];
        it.opp_pos4   = lit[3];
        it.opp_pos5   = lit[4];
        it.edge_front = front;
        it.edge_rear  = rear;
        return it;
    endfunction

    // Edge reading: mostly clear of the threshold, sometimes below it, sometimes anything
    function automatic logic [11:0] random_edge();
        int thr;
        int r;
        thr = int'(cfg_now.edge_threshold);
        r = $urandom_range(0, 99);
        if (r < 8)
            return 12'($urandom_range(0, 4095));
        if (r < 14 && thr > 0)
            return 12'($urandom_range(0, thr - 1));
        return 12'($urandom_range(thr, 4095));
    endfunction

    function automatic in_item_t random_tick();
        logic [4:0] lit;
        lit = ($urandom_range(0, 4) == 0) ? 5'd0 : 5'($urandom_range(1, 31));
        return make_item(lit, random_edge(), random_edge());
    endfunction

    function automatic int pick_gap();
        int r;
        if (sender_no_gaps)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic void add_tick(input logic [4:0] lit, input logic [11:0] front,
                                     input logic [11:0] rear);
        step_row_t row;
        row = '{default: '0};
        row.item = make_item(lit, front, rear);
        directed_rows.push_back(row);
    endfunction

    function automatic void add_typed(input logic [4:0] lit, input logic [11:0] front,
                                      input logic [11:0] rear, input logic [7:0] left,
                                      input logic [7:0] right,
                                      input logic signed [11:0] err, input logic [1:0] m);
        step_row_t row;
        row = '{default: '0};
        row.item = make_item(lit, front, rear);
        row.typed = 1'b1;
        row.typed_res.left_drive  = left;
        row.typed_res.right_drive = right;
        row.typed_res.steer_error = err;
        row.typed_res.mode        = m;
        directed_rows.push_back(row);
    endfunction

    function automatic void add_write(input logic [2:0] idx, input logic [15:0] val);
        step_row_t row;
        row = '{default: '0};
        row.is_write  = 1'b1;
        row.reg_index = idx;
        row.reg_value = val;
        directed_rows.push_back(row);
    endfunction

    // Send one request, then record its expected result once accepted
    task automatic send_tick(input in_item_t it, input bit typed, input out_item_t typed_res);
        int        gap;
        out_item_t pred;
        @(negedge clk);
        gap = pick_gap();
        if (gap != 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_data  = it;
        in_valid = 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        pred = predict_drive(it);
        pending_drive_q.push_back(typed ? typed_res : pred);
    endtask

    // Drop the request line and hold until every expected result has arrived
    task automatic wait_drained();
        int        guard;
        out_item_t missing_res;
        @(negedge clk);
        in_valid = 1'b0;
        guard = 0;
        while (pending_drive_q.size() != 0 && guard < DRAIN_GUARD)
        begin
            @(posedge clk);
            guard++;
        end
        while (pending_drive_q.size() != 0)
        begin
            missing_res = pending_drive_q.pop_front();
            report_mismatch("never arrived, mode", -1, int'(missing_res.mode));
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_STOP_LEFT:      cfg_now.stop_left      = val[7:0];
            REG_STOP_RIGHT:     cfg_now.stop_right     = val[7:0];
            REG_EDGE_THRESHOLD: cfg_now.edge_threshold = val[11:0];
            REG_SPEED_SLOW:     cfg_now.speed_slow     = val[6:0];
            REG_SPEED_FAST:     cfg_now.speed_fast     = val[6:0];
            REG_CENTER_BAND:    cfg_now.center_band    = val[10:0];
            REG_REVERSE_TICKS:  cfg_now.reverse_ticks  = val;
            REG_SPIN_TICKS:     cfg_now.spin_ticks     = val;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Program all registers for one random phase; the first three are fixed corners
    task automatic program_phase(input int p);
        logic [15:0] vals [NUM_REGS];
        case (p)
            0: vals = '{16'd140, 16'd140, 16'd300, 16'd70, 16'd90, 16'd100, 16'd3, 16'd4};
            1: vals = '{16'd0, 16'd255, 16'd4095, 16'd0, 16'd127, 16'd0, 16'd0, 16'd1};
            2: vals = '{16'd255, 16'd0, 16'd0, 16'd127, 16'd0, 16'd2047,
                        16'hFFFF, 16'hFFFF};
            default:
            begin
                vals[REG_STOP_LEFT]      = 16'($urandom_range(0, 255));
                vals[REG_STOP_RIGHT]     = 16'($urandom_range(0, 255));
                vals[REG_EDGE_THRESHOLD] = 16'($urandom_range(0, 4095));
                vals[REG_SPEED_SLOW]     = 16'($urandom_range(0, 127));
                vals[REG_SPEED_FAST]     = 16'($urandom_range(0, 127));
                vals[REG_CENTER_BAND]    = 16'($urandom_range(0, 2047));
                vals[REG_REVERSE_TICKS]  = 16'($urandom_range(0, 6));
                vals[REG_SPIN_TICKS]     = 16'($urandom_range(0, 6));
            end
        endcase
        wait_drained();
        // Array position matches the register index
        for (int r = 0; r < NUM_REGS; r++)
            write_reg(3'(r), vals[r]);
    endtask

    function automatic void build_directed_rows();
        // Reset defaults, dark sensors, edges clear
        add_typed(5'b00000, 12'd4095, 12'd4095, 8'd243, 8'd39, 12'sd0, MODE_TRACK);
        // Outermost sensors, all lit, pairs, hold on dark, truncating divide
        add_tick(5'b00001, 12'd4095, 12'd4095);
        add_tick(5'b10000, 12'd4095, 12'd4095);
        add_tick(5'b11111, 12'd4095, 12'd4095);
        add_tick(5'b00011, 12'd4095, 12'd4095);
        add_tick(5'b00000, 12'd4095, 12'd4095);
        add_tick(5'b01011, 12'd4095, 12'd4095);
        // Edge equal to the threshold does not trip
        add_tick(5'b00000, 12'd300, 12'd300);
        add_write(REG_REVERSE_TICKS, 16'd2);
        add_write(REG_SPIN_TICKS, 16'd1);
        // Trip: full reverse with the held error
        add_typed(5'b00000, 12'd299, 12'd4095, 8'd0, 8'd232, -12'sd667, MODE_REVERSE);
        // Error still updates during escape; edges ignored until it ends
        add_tick(5'b10000, 12'd0, 12'd0);
        add_tick(5'b00000, 12'd0, 12'd0);
        // Escape ends with an edge still low: restart on the same tick
        add_tick(5'b00000, 12'd0, 12'd4095);
        add_tick(5'b00000, 12'd4095, 12'd4095);
        add_tick(5'b00000, 12'd4095, 12'd4095);
        add_tick(5'b00000, 12'd4095, 12'd4095);
        // Both lengths zero: the tripping tick stays a tracking tick
        add_write(REG_REVERSE_TICKS, 16'd0);
        add_write(REG_SPIN_TICKS, 16'd0);
        add_tick(5'b00100, 12'd4095, 12'd0);
        // Zero reverse length goes straight to spin
        add_write(REG_SPIN_TICKS, 16'd2);
        add_tick(5'b00000, 12'd4095, 12'd0);
        add_tick(5'b00000, 12'd4095, 12'd4095);
        // Speed above 100 and extreme stop bytes, threshold zero never trips
        add_write(REG_STOP_LEFT, 16'd0);
        add_write(REG_STOP_RIGHT, 16'd255);
        add_write(REG_EDGE_THRESHOLD, 16'd0);
        add_write(REG_SPEED_FAST, 16'd127);
        add_write(REG_SPEED_SLOW, 16'd127);
        add_write(REG_CENTER_BAND, 16'd2047);
        add_tick(5'b10000, 12'd0, 12'd0);
        // Opposite stop corners, zero slow speed, top threshold
        add_write(REG_STOP_LEFT, 16'd255);
        add_write(REG_STOP_RIGHT, 16'd0);
        add_write(REG_EDGE_THRESHOLD, 16'd4095);
        add_write(REG_SPEED_SLOW, 16'd0);
        add_write(REG_CENTER_BAND, 16'd0);
        add_tick(5'b00001, 12'd4095, 12'd4095);
        add_tick(5'b11111, 12'd4094, 12'd4095);
    endfunction

    // Result checker: compare each accepted result with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_drive_q.size() == 0)
                report_mismatch("with no request pending, mode", int'(out_data.mode), -1);
            else
            begin
                want_res = pending_drive_q.pop_front();
                if (out_data.left_drive !== want_res.left_drive)
                    report_mismatch("left_drive", int'(out_data.left_drive),
                                    int'(want_res.left_drive));
                if (out_data.right_drive !== want_res.right_drive)
                    report_mismatch("right_drive", int'(out_data.right_drive),
                                    int'(want_res.right_drive));
                if (out_data.steer_error !== want_res.steer_error)
                    report_mismatch("steer_error", int'($signed(out_data.steer_error)),
                                    int'($signed(want_res.steer_error)));
                if (out_data.mode !== want_res.mode)
                    report_mismatch("mode", int'(out_data.mode), int'(want_res.mode));
            end
        end
    end

    // Receiver stalls: short and long runs, with quiet stretches between
    initial
    begin
        int r;
        forever
        begin
            r = $urandom_range(0, 99);
            if (r < 10)
            begin
                out_stall = 1'b0;
                repeat ($urandom_range(40, 150)) @(negedge clk);
            end
            else if (r < 55)
            begin
                out_stall = 1'b0;
                repeat ($urandom_range(1, 12)) @(negedge clk);
            end
            else if (r < 92)
            begin
                out_stall = 1'b1;
                repeat ($urandom_range(1, 3)) @(negedge clk);
            end
            else
            begin
                out_stall = 1'b1;
                repeat ($urandom_range(10, 60)) @(negedge clk);
            end
        end
    end

    // Main sequence: reset, directed rows, random phases, drain
    initial
    begin
        int p;
        int n;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        in_data        = '0;
        cfg_valid      = 1'b0;
        cfg_index      = REG_STOP_LEFT;
        cfg_data       = '0;
        mismatch_count = 0;
        sender_no_gaps = 1'b0;
        cfg_now        = '{8'd140, 8'd140, 12'd300, 7'd70, 7'd90, 11'd100, 16'd150, 16'd200};
        err_hold       = 0;
        esc_phase      = MODE_TRACK;
        esc_remaining  = '0;
        build_directed_rows();

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].is_write)
            begin
                wait_drained();
                write_reg(directed_rows[i].reg_index, directed_rows[i].reg_value);
            end
            else
                send_tick(directed_rows[i].item, directed_rows[i].typed,
                          directed_rows[i].typed_res);
        end

        for (p = 0; p < NUM_PHASES; p++)
        begin
            program_phase(p);
            sender_no_gaps = ($urandom_range(0, 3) == 0);
            for (n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                // Hold off mid-phase until the block has delivered everything
                if (n == ITEMS_PER_PHASE / 2)
                    wait_drained();
                send_tick(random_tick(), 1'b0, '0);
            end
        end

        wait_drained();
        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
